[src/pds_pkg.sv]
package pds_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int EPS_BITS       = 15;
  localparam logic [EPS_BITS-1:0] EPS_RESET = 15'd1;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_STEP_ZERO = 4'd7;
  localparam logic [STEP_W-1:0] LAST_STEP_FULL = 4'd12;

  typedef enum logic [3:0] {
    OPD_UX,
    OPD_UY,
    OPD_VX,
    OPD_VY,
    OPD_EPS,
    OPD_CR_HI,
    OPD_CR_LO,
    OPD_E2_HI,
    OPD_E2_LO,
    OPD_LN_HI,
    OPD_LN_LO
  } operand_e;

  typedef enum logic [1:0] {
    SH_0,
    SH_1,
    SH_2
  } shift_e;

  typedef enum logic [1:0] {
    LT_NONE,
    LT_CROSS,
    LT_LEN,
    LT_EPS2
  } latch_e;

  typedef struct packed {
    operand_e a;
    operand_e b;
    shift_e   sh;
    logic     sub;
    logic     clr;
    latch_e   lt;
  } uop_t;

  typedef struct packed {
    logic capture;
    logic mac_en;
    uop_t uop;
    logic anchor_from_new;
    logic anchor_from_pend;
    logic pend_from_new;
    logic out_from_new;
    logic out_from_pend;
  } cmd_t;

  typedef struct packed {
    logic zero_len;
    logic drop;
    logic out_free;
    logic new_end;
  } status_t;

  function automatic uop_t mk_uop(operand_e a, operand_e b, shift_e sh, logic sub, logic clr,
                                  latch_e lt);
    uop_t u;
    u.a   = a;
    u.b   = b;
    u.sh  = sh;
    u.sub = sub;
    u.clr = clr;
    u.lt  = lt;
    return u;
  endfunction

  // Products are accumulated into one signed sum whose sign gives the decision.
  function automatic uop_t uop_at(logic [STEP_W-1:0] step, logic zero_len);
    uop_t u;
    u = mk_uop(OPD_EPS, OPD_EPS, SH_0, 1'b0, 1'b0, LT_NONE);
    if (step < 4'd5) begin
      case (step)
        4'd0:    u = mk_uop(OPD_UX, OPD_VY, SH_0, 1'b0, 1'b1, LT_NONE);
        4'd1:    u = mk_uop(OPD_UY, OPD_VX, SH_0, 1'b1, 1'b0, LT_CROSS);
        4'd2:    u = mk_uop(OPD_UX, OPD_UX, SH_0, 1'b0, 1'b1, LT_NONE);
        4'd3:    u = mk_uop(OPD_UY, OPD_UY, SH_0, 1'b0, 1'b0, LT_LEN);
        4'd4:    u = mk_uop(OPD_EPS, OPD_EPS, SH_0, 1'b0, 1'b1, LT_EPS2);
        default: u = mk_uop(OPD_EPS, OPD_EPS, SH_0, 1'b0, 1'b0, LT_NONE);
      endcase
    end else if (zero_len) begin
      case (step)
        4'd5:    u = mk_uop(OPD_VX, OPD_VX, SH_0, 1'b0, 1'b1, LT_NONE);
        4'd6:    u = mk_uop(OPD_VY, OPD_VY, SH_0, 1'b0, 1'b0, LT_NONE);
        4'd7:    u = mk_uop(OPD_EPS, OPD_EPS, SH_0, 1'b1, 1'b0, LT_NONE);
        default: u = mk_uop(OPD_EPS, OPD_EPS, SH_0, 1'b0, 1'b0, LT_NONE);
      endcase
    end else begin
      case (step)
        4'd5:    u = mk_uop(OPD_CR_HI, OPD_CR_HI, SH_2, 1'b0, 1'b1, LT_NONE);
        4'd6:    u = mk_uop(OPD_CR_HI, OPD_CR_LO, SH_1, 1'b0, 1'b0, LT_NONE);
        4'd7:    u = mk_uop(OPD_CR_HI, OPD_CR_LO, SH_1, 1'b0, 1'b0, LT_NONE);
        4'd8:    u = mk_uop(OPD_CR_LO, OPD_CR_LO, SH_0, 1'b0, 1'b0, LT_NONE);
        4'd9:    u = mk_uop(OPD_E2_HI, OPD_LN_HI, SH_2, 1'b1, 1'b0, LT_NONE);
        4'd10:   u = mk_uop(OPD_E2_HI, OPD_LN_LO, SH_1, 1'b1, 1'b0, LT_NONE);
        4'd11:   u = mk_uop(OPD_E2_LO, OPD_LN_HI, SH_1, 1'b1, 1'b0, LT_NONE);
        4'd12:   u = mk_uop(OPD_E2_LO, OPD_LN_LO, SH_0, 1'b1, 1'b0, LT_NONE);
        default: u = mk_uop(OPD_EPS, OPD_EPS, SH_0, 1'b0, 1'b0, LT_NONE);
      endcase
    end
    return u;
  endfunction

endpackage

[src/pds_ctrl.sv]
module pds_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pds_pkg::status_t  sts_i,
  output pds_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DECIDE,
    ST_EMIT_PEND,
    ST_FINISH,
    ST_EMIT_NEW
  } state_e;

  state_e                       state_q;
  logic [pds_pkg::STEP_W-1:0]   step_q;
  logic                         in_path_q;
  logic                         has_pending_q;
  logic                         last_step;

  assign last_step  = (step_q == (sts_i.zero_len ? pds_pkg::LAST_STEP_ZERO
                                                 : pds_pkg::LAST_STEP_FULL));
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o                  = '0;
    cmd_o.uop              = pds_pkg::uop_at(step_q, sts_i.zero_len);
    cmd_o.capture          = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mac_en           = (state_q == ST_RUN);
    cmd_o.out_from_pend    = (state_q == ST_EMIT_PEND) && sts_i.out_free;
    cmd_o.anchor_from_pend = (state_q == ST_EMIT_PEND) && sts_i.out_free;
    cmd_o.out_from_new     = (state_q == ST_EMIT_NEW) && sts_i.out_free;
    cmd_o.anchor_from_new  = (state_q == ST_EMIT_NEW) && sts_i.out_free;
    cmd_o.pend_from_new    = (state_q == ST_FINISH) && !sts_i.new_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      step_q        <= '0;
      in_path_q     <= 1'b0;
      has_pending_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            step_q <= '0;
            if (!in_path_q) begin
              state_q <= ST_EMIT_NEW;
            end else if (has_pending_q) begin
              state_q <= ST_RUN;
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_RUN: begin
          step_q <= step_q + 1'b1;
          if (last_step) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          has_pending_q <= 1'b0;
          state_q       <= sts_i.drop ? ST_FINISH : ST_EMIT_PEND;
        end
        ST_EMIT_PEND: begin
          if (sts_i.out_free) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (sts_i.new_end) begin
            state_q <= ST_EMIT_NEW;
          end else begin
            has_pending_q <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end
        ST_EMIT_NEW: begin
          if (sts_i.out_free) begin
            in_path_q     <= !sts_i.new_end;
            has_pending_q <= 1'b0;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[src/pds_datapath.sv]
module pds_datapath #(
  parameter int CoordBits = pds_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         epsilon_we_i,
  input  logic [pds_pkg::EPS_BITS-1:0] epsilon_i,
  input  logic signed [CoordBits-1:0]  x_coord_i,
  input  logic signed [CoordBits-1:0]  y_coord_i,
  input  logic                         path_end_i,
  output logic signed [CoordBits-1:0]  out_x_o,
  output logic signed [CoordBits-1:0]  out_y_o,
  output logic                         out_end_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  pds_pkg::cmd_t                cmd_i,
  output pds_pkg::status_t             sts_o
);

  localparam int DiffW  = CoordBits + 1;
  localparam int DigW   = (DiffW > 16) ? DiffW : 16;
  localparam int OpW    = DigW + 1;
  localparam int ProdW  = 2 * OpW;
  localparam int CrossW = 2 * DiffW + 1;
  localparam int AccW   = 4 * DigW + 4;

  logic [pds_pkg::EPS_BITS-1:0] eps_q;
  logic signed [CoordBits-1:0]  anchor_x_q, anchor_y_q, pend_x_q, pend_y_q;
  logic signed [CoordBits-1:0]  new_x_q, new_y_q;
  logic                         new_end_q;
  logic signed [DiffW-1:0]      ux_q, uy_q, vx_q, vy_q;
  logic signed [CrossW-1:0]     cross_q;
  logic [2*DigW-1:0]            len2_q, eps2_q;
  logic signed [ProdW-1:0]      p_q;
  logic                         ctl_vld_q;
  pds_pkg::uop_t                ctl_q;
  logic signed [AccW-1:0]       acc_q, acc_d, term, base;
  logic signed [OpW-1:0]        a_op, b_op;
  logic signed [2*DigW:0]       cross_ext;
  logic                         out_free;

  assign cross_ext = (2 * DigW + 1)'(cross_q);
  assign out_free  = !out_valid_o || !out_stall_i;

  function automatic logic signed [OpW-1:0] pick(
    pds_pkg::operand_e       sel,
    logic signed [DiffW-1:0] ux,
    logic signed [DiffW-1:0] uy,
    logic signed [DiffW-1:0] vx,
    logic signed [DiffW-1:0] vy,
    logic [pds_pkg::EPS_BITS-1:0] eps,
    logic signed [2*DigW:0]  crx,
    logic [2*DigW-1:0]       e2,
    logic [2*DigW-1:0]       ln
  );
    logic signed [OpW-1:0] r;
    case (sel)
      pds_pkg::OPD_UX:    r = OpW'(ux);
      pds_pkg::OPD_UY:    r = OpW'(uy);
      pds_pkg::OPD_VX:    r = OpW'(vx);
      pds_pkg::OPD_VY:    r = OpW'(vy);
      pds_pkg::OPD_EPS:   r = OpW'(eps);
      pds_pkg::OPD_CR_HI: r = crx[2*DigW:DigW];
      pds_pkg::OPD_CR_LO: r = OpW'(crx[DigW-1:0]);
      pds_pkg::OPD_E2_HI: r = OpW'(e2[2*DigW-1:DigW]);
      pds_pkg::OPD_E2_LO: r = OpW'(e2[DigW-1:0]);
      pds_pkg::OPD_LN_HI: r = OpW'(ln[2*DigW-1:DigW]);
      pds_pkg::OPD_LN_LO: r = OpW'(ln[DigW-1:0]);
      default:            r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    a_op = pick(cmd_i.uop.a, ux_q, uy_q, vx_q, vy_q, eps_q, cross_ext, eps2_q, len2_q);
    b_op = pick(cmd_i.uop.b, ux_q, uy_q, vx_q, vy_q, eps_q, cross_ext, eps2_q, len2_q);
  end

  always_comb begin
    case (ctl_q.sh)
      pds_pkg::SH_1: term = AccW'(p_q) <<< DigW;
      pds_pkg::SH_2: term = AccW'(p_q) <<< (2 * DigW);
      default:       term = AccW'(p_q);
    endcase
    base  = ctl_q.clr ? '0 : acc_q;
    acc_d = ctl_q.sub ? (base - term) : (base + term);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q       <= pds_pkg::EPS_RESET;
      ctl_vld_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (epsilon_we_i) begin
        eps_q <= epsilon_i;
      end
      ctl_vld_q <= cmd_i.mac_en;
      if (cmd_i.out_from_new || cmd_i.out_from_pend) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= a_op * b_op;
    ctl_q <= cmd_i.uop;
    if (ctl_vld_q) begin
      acc_q <= acc_d;
      case (ctl_q.lt)
        pds_pkg::LT_CROSS: cross_q <= acc_d[CrossW-1:0];
        pds_pkg::LT_LEN:   len2_q  <= acc_d[2*DigW-1:0];
        pds_pkg::LT_EPS2:  eps2_q  <= acc_d[2*DigW-1:0];
        default: begin
        end
      endcase
    end
    if (cmd_i.capture) begin
      new_x_q   <= x_coord_i;
      new_y_q   <= y_coord_i;
      new_end_q <= path_end_i;
      ux_q      <= DiffW'(x_coord_i) - DiffW'(anchor_x_q);
      uy_q      <= DiffW'(y_coord_i) - DiffW'(anchor_y_q);
      vx_q      <= DiffW'(pend_x_q) - DiffW'(anchor_x_q);
      vy_q      <= DiffW'(pend_y_q) - DiffW'(anchor_y_q);
    end
    if (cmd_i.anchor_from_new) begin
      anchor_x_q <= new_x_q;
      anchor_y_q <= new_y_q;
    end else if (cmd_i.anchor_from_pend) begin
      anchor_x_q <= pend_x_q;
      anchor_y_q <= pend_y_q;
    end
    if (cmd_i.pend_from_new) begin
      pend_x_q <= new_x_q;
      pend_y_q <= new_y_q;
    end
    if (cmd_i.out_from_new) begin
      out_x_o   <= new_x_q;
      out_y_o   <= new_y_q;
      out_end_o <= new_end_q;
    end else if (cmd_i.out_from_pend) begin
      out_x_o   <= pend_x_q;
      out_y_o   <= pend_y_q;
      out_end_o <= 1'b0;
    end
  end

  assign sts_o.zero_len = (ux_q == '0) && (uy_q == '0);
  assign sts_o.drop     = acc_q[AccW-1];
  assign sts_o.out_free = out_free;
  assign sts_o.new_end  = new_end_q;

endmodule

[src/polyline_distance_simplifier.sv]
// Channel   Direction  Handshake                 Word
// input     in         in_valid_i / in_stall_o   x_coord_i, y_coord_i, path_end_i
// output    out        out_valid_o / out_stall_i out_x_o, out_y_o, out_end_o
// config    in         epsilon_we_i              epsilon_i
//
// A point that opens a path, or that arrives with no pending point, skips the product steps.
// An interior decision runs the product steps: one shared multiplier forms one product per cycle,
// 13 products in all, or 8 when the new point equals the anchor.
// Reset is asynchronous and active low; epsilon returns to 1 and no path is open.
// A stalled output holds its word and the block waits in its emit state until it is taken.
module polyline_distance_simplifier #(
  parameter int CoordBits = pds_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         epsilon_we_i,
  input  logic [pds_pkg::EPS_BITS-1:0] epsilon_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [CoordBits-1:0]  x_coord_i,
  input  logic signed [CoordBits-1:0]  y_coord_i,
  input  logic                         path_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [CoordBits-1:0]  out_x_o,
  output logic signed [CoordBits-1:0]  out_y_o,
  output logic                         out_end_o
);

  pds_pkg::cmd_t    cmd;
  pds_pkg::status_t sts;

  pds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pds_datapath #(
    .CoordBits (CoordBits)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .epsilon_we_i (epsilon_we_i),
    .epsilon_i    (epsilon_i),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .path_end_i   (path_end_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_end_o    (out_end_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule
